// ===== rtl/qps_pkg.sv =====
// ----------------------------------------------------------------------------
// qps_pkg
// Types and constants shared by the quadrature position servo.
// ----------------------------------------------------------------------------
`default_nettype none

package qps_pkg;

  localparam int unsigned NumPresets = 5;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_CONTROL = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    CFG_PRE45     = 3'd0,
    CFG_PLACE45   = 3'd1,
    CFG_PRE25     = 3'd2,
    CFG_PLACE25   = 3'd3,
    CFG_BOTTOM    = 3'd4,
    CFG_GAIN      = 3'd5,
    CFG_TOLERANCE = 3'd6,
    CFG_DUTY_LIM  = 3'd7
  } cfg_idx_e;

  localparam logic [2:0] MODE_STOP = 3'd5;

  localparam logic signed [31:0] RstPre45Pos   = -32'sd5000;
  localparam logic signed [31:0] RstPlace45Pos = -32'sd3750;
  localparam logic signed [31:0] RstPre25Pos   = -32'sd4400;
  localparam logic signed [31:0] RstPlace25Pos = -32'sd5375;
  localparam logic signed [31:0] RstBottomPos  = 32'sd0;
  localparam logic [7:0]         RstGain       = 8'd5;
  localparam logic [15:0]        RstTolerance  = 16'd3;
  localparam logic [9:0]         RstDutyLimit  = 10'd400;

  typedef struct packed {
    logic [1:0] req_type;
    logic       enc_a;
    logic       enc_b;
    logic [2:0] preset;
  } req_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [9:0]         duty;
    logic               clockwise;
    logic               at_target;
    logic               glitch;
    logic [2:0]         mode;
  } res_t;

  typedef struct packed {
    logic signed [31:0] pre45_position;
    logic signed [31:0] place45_position;
    logic signed [31:0] pre25_position;
    logic signed [31:0] place25_position;
    logic signed [31:0] bottom_position;
    logic [7:0]         gain;
    logic [15:0]        tolerance;
    logic [9:0]         duty_limit;
  } cfg_t;

  typedef struct packed {
    logic glitch;
    logic count_en;
    logic count_dn;
  } quad_step_t;

  typedef struct packed {
    logic [9:0] duty;
    logic       clockwise;
    logic       settled;
  } drive_t;

endpackage

`default_nettype wire

// ===== rtl/qps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qps_cfg_regs
// Configuration register file: preset targets, gain, dead band, duty limit.
// ----------------------------------------------------------------------------
`default_nettype none

module qps_cfg_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  output qps_pkg::cfg_t    cfg_o
);
  import qps_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre45_position   <= RstPre45Pos;
      cfg_q.place45_position <= RstPlace45Pos;
      cfg_q.pre25_position   <= RstPre25Pos;
      cfg_q.place25_position <= RstPlace25Pos;
      cfg_q.bottom_position  <= RstBottomPos;
      cfg_q.gain             <= RstGain;
      cfg_q.tolerance        <= RstTolerance;
      cfg_q.duty_limit       <= RstDutyLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PRE45:     cfg_q.pre45_position   <= cfg_wdata_i;
        CFG_PLACE45:   cfg_q.place45_position <= cfg_wdata_i;
        CFG_PRE25:     cfg_q.pre25_position   <= cfg_wdata_i;
        CFG_PLACE25:   cfg_q.place25_position <= cfg_wdata_i;
        CFG_BOTTOM:    cfg_q.bottom_position  <= cfg_wdata_i;
        CFG_GAIN:      cfg_q.gain             <= cfg_wdata_i[7:0];
        CFG_TOLERANCE: cfg_q.tolerance        <= cfg_wdata_i[15:0];
        CFG_DUTY_LIM:  cfg_q.duty_limit       <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/qps_quad_dec.sv =====
// ----------------------------------------------------------------------------
// qps_quad_dec
// Quadrature edge decode of one A/B sample against the stored levels.
// ----------------------------------------------------------------------------
`default_nettype none

module qps_quad_dec (
  input  wire logic          last_a_i,
  input  wire logic          last_b_i,
  input  wire logic          enc_a_i,
  input  wire logic          enc_b_i,
  output qps_pkg::quad_step_t step_o
);
  import qps_pkg::*;

  logic ch_a;
  logic ch_b;
  logic same;

  always_comb begin
    ch_a = enc_a_i ^ last_a_i;
    ch_b = enc_b_i ^ last_b_i;
    same = ~(enc_a_i ^ enc_b_i);
    step_o.glitch   = ch_a & ch_b;
    step_o.count_en = ch_a ^ ch_b;
    // A alone: down when equal; B alone: up when equal
    step_o.count_dn = ch_a ? same : ~same;
  end

endmodule

`default_nettype wire

// ===== rtl/qps_drive_calc.sv =====
// ----------------------------------------------------------------------------
// qps_drive_calc
// Proportional drive: error to target, dead band, gain, duty saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module qps_drive_calc (
  input  wire logic [2:0]         preset_i,
  input  wire logic signed [31:0] position_i,
  input  qps_pkg::cfg_t           cfg_i,
  output qps_pkg::drive_t         drive_o
);
  import qps_pkg::*;

  logic signed [31:0] target;
  logic signed [32:0] err;
  logic [32:0]        mag;
  logic               outside;
  logic               big;
  logic [17:0]        prod;
  logic [9:0]         duty;

  always_comb begin
    unique case (preset_i)
      3'd0:    target = cfg_i.pre45_position;
      3'd1:    target = cfg_i.place45_position;
      3'd2:    target = cfg_i.pre25_position;
      3'd3:    target = cfg_i.place25_position;
      default: target = cfg_i.bottom_position;
    endcase

    err     = {target[31], target} - {position_i[31], position_i};
    mag     = err[32] ? 33'(-err) : 33'(err);
    outside = mag > {17'd0, cfg_i.tolerance};
    // magnitude of 1024 or more saturates whenever gain is nonzero
    big     = |mag[32:10];
    prod    = mag[9:0] * cfg_i.gain;

    if (cfg_i.gain == 8'd0) begin
      duty = 10'd0;
    end else if (big || (prod > {8'd0, cfg_i.duty_limit})) begin
      duty = cfg_i.duty_limit;
    end else begin
      duty = prod[9:0];
    end

    if (outside) begin
      drive_o.duty      = duty;
      drive_o.clockwise = err[32] & (cfg_i.gain != 8'd0);
      drive_o.settled   = 1'b0;
    end else begin
      drive_o.duty      = 10'd0;
      drive_o.clockwise = 1'b0;
      drive_o.settled   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quadrature_position_servo.sv =====
// ----------------------------------------------------------------------------
// quadrature_position_servo
// Quadrature encoder counter with proportional position drive.
// ----------------------------------------------------------------------------
// Each request (pin sample, control step or clear) gives one result showing
// the position, drive and mode after it. A request is captured in an input
// register, then processed against the servo state once the result register
// can take it and written there, so one request per clock is sustained while
// the output is not stalled. The user writes configuration through the
// plain write port only while no request is in flight; nothing enforces it.
`default_nettype none

module quadrature_position_servo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  qps_pkg::req_t    in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output qps_pkg::res_t    out_res_o
);
  import qps_pkg::*;

  cfg_t       cfg;
  quad_step_t step;
  drive_t     drive;

  logic               req_valid_q;
  req_t               req_q;
  logic               res_valid_q;
  res_t               res_q;
  res_t               res_d;
  logic               advance;
  logic               fire;

  logic               last_a_q, last_a_d;
  logic               last_b_q, last_b_d;
  logic signed [31:0] pos_q, pos_d;
  logic [9:0]         duty_q, duty_d;
  logic               cw_q, cw_d;
  logic               settled_q, settled_d;
  logic [2:0]         mode_q, mode_d;
  logic               glitch_d;

  qps_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  qps_quad_dec u_dec (
    .last_a_i (last_a_q),
    .last_b_i (last_b_q),
    .enc_a_i  (req_q.enc_a),
    .enc_b_i  (req_q.enc_b),
    .step_o   (step)
  );

  qps_drive_calc u_drive (
    .preset_i   (req_q.preset),
    .position_i (pos_q),
    .cfg_i      (cfg),
    .drive_o    (drive)
  );

  assign advance    = !res_valid_q || out_ready_i;
  assign fire       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  always_comb begin
    last_a_d  = last_a_q;
    last_b_d  = last_b_q;
    pos_d     = pos_q;
    duty_d    = duty_q;
    cw_d      = cw_q;
    settled_d = settled_q;
    mode_d    = mode_q;
    glitch_d  = 1'b0;
    unique case (req_type_e'(req_q.req_type))
      REQ_SAMPLE: begin
        last_a_d = req_q.enc_a;
        last_b_d = req_q.enc_b;
        glitch_d = step.glitch;
        if (step.count_en) begin
          pos_d = step.count_dn ? pos_q - 32'sd1 : pos_q + 32'sd1;
        end
      end
      REQ_CONTROL: begin
        if (req_q.preset >= MODE_STOP) begin
          mode_d    = MODE_STOP;
          duty_d    = 10'd0;
          cw_d      = 1'b0;
          settled_d = 1'b1;
        end else begin
          mode_d    = req_q.preset;
          duty_d    = drive.duty;
          cw_d      = drive.clockwise;
          settled_d = drive.settled;
        end
      end
      REQ_CLEAR: pos_d = 32'sd0;
      default: ;
    endcase

    res_d.position  = pos_d;
    res_d.duty      = duty_d;
    res_d.clockwise = cw_d;
    res_d.at_target = settled_d;
    res_d.glitch    = glitch_d;
    res_d.mode      = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      last_a_q    <= 1'b0;
      last_b_q    <= 1'b0;
      pos_q       <= 32'sd0;
      duty_q      <= 10'd0;
      cw_q        <= 1'b0;
      settled_q   <= 1'b0;
      mode_q      <= MODE_STOP;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= req_valid_q;
      end
      if (fire) begin
        last_a_q  <= last_a_d;
        last_b_q  <= last_b_d;
        pos_q     <= pos_d;
        duty_q    <= duty_d;
        cw_q      <= cw_d;
        settled_q <= settled_d;
        mode_q    <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

// ===== tb/quadrature_position_servo_tb.sv =====
// ----------------------------------------------------------------------------
// quadrature_position_servo_tb
// Self-checking bench for the quadrature position servo: directed quadrature
// walks, glitches, every preset, clear and unused request types, then random
// request streams over several configurations and idle/stall patterns. Each
// result is checked field by field against a model of the servo state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quadrature_position_servo_tb;
  import qps_pkg::*;

  localparam int StallLimit = 2000;
  localparam int NumPhases = 8;
  localparam int PhaseRequests = 165;

  class servo_scoreboard;
    logic signed [31:0] target_pos [NumPresets];
    logic [7:0]         gain;
    logic [15:0]        tolerance;
    logic [9:0]         duty_limit;
    logic               last_a;
    logic               last_b;
    logic signed [31:0] position;
    logic [9:0]         duty;
    logic               clockwise;
    logic               settled;
    logic [2:0]         mode;
    res_t               expected_q [$];
    int                 errors;
    int                 requests;
    int                 results;
    int                 glitches;
    int                 saturated;
    int                 settled_steps;

    function new();
      target_pos[0] = RstPre45Pos;
      target_pos[1] = RstPlace45Pos;
      target_pos[2] = RstPre25Pos;
      target_pos[3] = RstPlace25Pos;
      target_pos[4] = RstBottomPos;
      gain = RstGain;
      tolerance = RstTolerance;
      duty_limit = RstDutyLimit;
      last_a = 1'b0;
      last_b = 1'b0;
      position = '0;
      duty = '0;
      clockwise = 1'b0;
      settled = 1'b0;
      mode = MODE_STOP;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_GAIN: gain = data[7:0];
        CFG_TOLERANCE: tolerance = data[15:0];
        CFG_DUTY_LIM: duty_limit = data[9:0];
        default: target_pos[int'(idx)] = data;
      endcase
    endfunction

    function void halt_drive();
      duty = '0;
      clockwise = 1'b0;
      settled = 1'b1;
    endfunction

    function void note_request(req_t r);
      res_t   e;
      logic   glitch;
      longint err;
      longint mag;
      longint drive;
      glitch = 1'b0;
      case (req_type_e'(r.req_type))
        REQ_SAMPLE: begin
          if (r.enc_a != last_a && r.enc_b != last_b) begin
            glitch = 1'b1;
          end else if (r.enc_a != last_a) begin
            position += (r.enc_a == r.enc_b) ? -1 : 1;
          end else if (r.enc_b != last_b) begin
            position += (r.enc_a == r.enc_b) ? 1 : -1;
          end
          glitches += glitch;
          last_a = r.enc_a;
          last_b = r.enc_b;
        end
        REQ_CONTROL: begin
          if (r.preset >= MODE_STOP) begin
            mode = MODE_STOP;
            halt_drive();
          end else begin
            mode = r.preset;
            // exact difference, no 32-bit wrap
            err = longint'(target_pos[r.preset]) - longint'(position);
            mag = (err < 0) ? -err : err;
            if (mag > longint'(tolerance)) begin
              drive = mag * longint'(gain);
              if (drive > longint'(duty_limit)) begin
                drive = longint'(duty_limit);
                saturated++;
              end
              duty = drive[9:0];
              clockwise = (err < 0) && (gain != 0);
              settled = 1'b0;
            end else begin
              halt_drive();
            end
          end
          settled_steps += settled;
        end
        REQ_CLEAR: position = '0;
        default: ;
      endcase
      e.position = position;
      e.duty = duty;
      e.clockwise = clockwise;
      e.at_target = settled;
      e.glitch = glitch;
      e.mode = mode;
      expected_q.push_back(e);
      requests++;
    endfunction

    function void compare(string name, logic signed [63:0] exp_v, logic signed [63:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: position %0d mode %0d",
               got.position, got.mode);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      results++;
      compare("position", e.position, got.position);
      compare("duty", e.duty, got.duty);
      compare("clockwise", e.clockwise, got.clockwise);
      compare("at_target", e.at_target, got.at_target);
      compare("glitch", e.glitch, got.glitch);
      compare("mode", e.mode, got.mode);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  res_t        out_res_o;

  servo_scoreboard sb = new();

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  logic lvl_a = 1'b0;
  logic lvl_b = 1'b0;
  bit   walk_up = 1'b1;

  quadrature_position_servo u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_request(in_req_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_res_o);
    end
    if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no handshake for %0d cycles", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // random filler in the fields that the request type does not use
  function automatic req_t typed_req(req_type_e t);
    req_t r;
    r = 7'($urandom());
    r.req_type = t;
    return r;
  endfunction

  function automatic req_t sample_req(logic a, logic b);
    req_t r;
    r = typed_req(REQ_SAMPLE);
    r.enc_a = a;
    r.enc_b = b;
    lvl_a = a;
    lvl_b = b;
    return r;
  endfunction

  // one legal quadrature step in the requested direction
  function automatic req_t walk_req(bit up);
    if ((lvl_a == lvl_b) == up) begin
      return sample_req(~lvl_a, lvl_b);
    end
    return sample_req(lvl_a, ~lvl_b);
  endfunction

  function automatic req_t control_req(logic [2:0] p);
    req_t r;
    r = typed_req(REQ_CONTROL);
    r.preset = p;
    return r;
  endfunction

  function automatic req_t next_random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      walk_up = ~walk_up;
    end
    if (pick < 55) begin
      r = walk_req(walk_up);
    end else if (pick < 60) begin
      r = sample_req(~lvl_a, ~lvl_b);
    end else if (pick < 64) begin
      r = sample_req(lvl_a, lvl_b);
    end else if (pick < 84) begin
      r = control_req(($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                               : 3'($urandom_range(5)));
    end else if (pick < 89) begin
      r = typed_req(REQ_CLEAR);
    end else if (pick < 92) begin
      r = typed_req(REQ_NONE);
    end else begin
      r = 7'($urandom());
      if (r.req_type == REQ_SAMPLE) begin
        lvl_a = r.enc_a;
        lvl_b = r.enc_b;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] near_pos(int spread);
    return sb.position + $urandom_range(2 * spread) - spread;
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // caller lowers the write enable after the last write of a batch
  task automatic load_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic setup_phase(input int ph);
    logic [31:0] tgt [NumPresets];
    logic [31:0] g;
    logic [31:0] t;
    logic [31:0] l;
    case (ph)
      1: begin
        tgt[0] = 32'h8000_0000;
        tgt[1] = 32'h7fff_ffff;
        tgt[2] = 32'h8000_0000;
        tgt[3] = 32'h7fff_ffff;
        tgt[4] = near_pos(20);
        g = 32'd255;
        t = 32'd0;
        l = 32'd1023;
      end
      2: begin
        for (int i = 0; i < NumPresets; i++) tgt[i] = near_pos(30);
        g = 32'd0;
        t = 32'd0;
        l = 32'd1023;
      end
      3: begin
        for (int i = 0; i < NumPresets - 1; i++) tgt[i] = $urandom();
        tgt[4] = near_pos(100);
        g = 32'd1;
        t = 32'd65535;
        l = 32'd0;
      end
      default: begin
        for (int i = 0; i < NumPresets; i++) tgt[i] = near_pos(60);
        g = $urandom_range(255);
        t = $urandom_range(12);
        l = $urandom_range(1023);
      end
    endcase
    load_reg(CFG_PRE45, tgt[0]);
    load_reg(CFG_PLACE45, tgt[1]);
    load_reg(CFG_PRE25, tgt[2]);
    load_reg(CFG_PLACE25, tgt[3]);
    load_reg(CFG_BOTTOM, tgt[4]);
    load_reg(CFG_GAIN, g);
    load_reg(CFG_TOLERANCE, t);
    load_reg(CFG_DUTY_LIM, l);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: walks, glitch, idle sample, every preset, clear, unused type
    send_req(sample_req(1'b0, 1'b0));
    repeat (4) send_req(walk_req(1'b1));
    repeat (2) send_req(walk_req(1'b0));
    send_req(sample_req(~lvl_a, ~lvl_b));
    send_req(sample_req(lvl_a, lvl_b));
    for (int p = 0; p < 8; p++) send_req(control_req(3'(p)));
    send_req(typed_req(REQ_CLEAR));
    send_req(typed_req(REQ_NONE));
    send_req(control_req(3'd4));
    repeat (5) send_req(walk_req(1'b0));
    send_req(control_req(3'd4));
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        setup_phase(ph);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (int i = 0; i < PhaseRequests; i++) begin
        send_req(next_random_req());
        if (i == PhaseRequests / 2) begin
          drain();
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Checked %0d results for %0d requests over %0d configurations and idle/stall mixes.",
             sb.results, sb.requests, NumPhases);
    $display("Covered %0d glitched samples, %0d saturated drives, %0d settled control steps.",
             sb.glitches, sb.saturated, sb.settled_steps);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qps_pkg.sv
rtl/qps_cfg_regs.sv
rtl/qps_quad_dec.sv
rtl/qps_drive_calc.sv
rtl/quadrature_position_servo.sv
tb/quadrature_position_servo_tb.sv
